@@ rtl/core/amoc_pkg.sv @@
// shared types, constants and rounding helper of the overlay compositor
package amoc_pkg;

   localparam int CANVAS_WIDTH_DEFAULT  = 128;
   localparam int CANVAS_HEIGHT_DEFAULT = 64;

   typedef enum logic [1:0] {
      CMD_BLEND   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_CONVERT = 2'd2,
      CMD_CLEAR   = 2'd3
   } command_type;

   // canvas word: alpha 31:24, red 23:16, green 15:8, blue 7:0
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // step enables from the sequencer to the blend datapath
   typedef struct packed {
      logic alpha_mul;
      logic alpha_div;
      logic chan_mul;
   } blend_ctrl_type;

   // (prod + 127) / 255 for prod up to 255*255, by reciprocal fold
   function automatic logic [7:0] div255_round(input logic [15:0] prod);
      logic [16:0] v;
      logic [16:0] q;
      v = {1'b0, prod} + 17'd127;
      q = v + (v >> 8) + 17'd1;
      return q[15:8];
   endfunction

endpackage

@@ rtl/core/amoc_canvas_ram.sv @@
// single-port canvas memory with registered read data
module amoc_canvas_ram #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  logic                clock,
   input  logic                en,
   input  logic                we,
   input  logic [ADDR_W-1:0]   addr,
   input  amoc_pkg::pixel_type wdata,
   output amoc_pkg::pixel_type rdata
);

   amoc_pkg::pixel_type mem [DEPTH];
   amoc_pkg::pixel_type rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/amoc_blend.sv @@
// alpha, premultiply and source-over datapath, stepped by the sequencer
module amoc_blend (
   input  logic                    clock,
   input  amoc_pkg::blend_ctrl_type ctrl,
   input  logic [7:0]              mask,
   input  logic [7:0]              opacity,
   input  logic [7:0]              src_blue,
   input  logic [7:0]              src_green,
   input  logic [7:0]              src_red,
   input  amoc_pkg::pixel_type     dst,
   output amoc_pkg::pixel_type     src_pixel,
   output amoc_pkg::pixel_type     over_pixel,
   output logic                    alpha_zero
);

   logic [15:0] alpha_prod_ff;
   logic [7:0]  alpha_ff;
   logic [15:0] src_prod_ff [3];
   logic [15:0] dst_prod_ff [4];
   logic [7:0]  inv;
   logic [7:0]  src_chan [3];
   logic [7:0]  dst_chan [4];
   logic [7:0]  src_all [4];
   logic [7:0]  over_chan [4];
   logic [8:0]  sum [4];

   assign inv = 8'hff - alpha_ff;

   always_ff @(posedge clock) begin
      if (ctrl.alpha_mul) begin
         alpha_prod_ff <= {8'd0, mask} * {8'd0, opacity};
      end
      if (ctrl.alpha_div) begin
         alpha_ff <= amoc_pkg::div255_round(alpha_prod_ff);
      end
      if (ctrl.chan_mul) begin
         src_prod_ff[0] <= {8'd0, src_blue} * {8'd0, alpha_ff};
         src_prod_ff[1] <= {8'd0, src_green} * {8'd0, alpha_ff};
         src_prod_ff[2] <= {8'd0, src_red} * {8'd0, alpha_ff};
         dst_prod_ff[0] <= {8'd0, dst.blue} * {8'd0, inv};
         dst_prod_ff[1] <= {8'd0, dst.green} * {8'd0, inv};
         dst_prod_ff[2] <= {8'd0, dst.red} * {8'd0, inv};
         dst_prod_ff[3] <= {8'd0, dst.alpha} * {8'd0, inv};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         src_chan[i] = amoc_pkg::div255_round(src_prod_ff[i]);
         src_all[i]  = src_chan[i];
      end
      src_all[3] = alpha_ff;
      for (int i = 0; i < 4; i++) begin
         dst_chan[i] = amoc_pkg::div255_round(dst_prod_ff[i]);
         sum[i]      = {1'b0, src_all[i]} + {1'b0, dst_chan[i]};
         // saturate as a guard; premultiplied input never overflows
         over_chan[i] = sum[i][8] ? 8'hff : sum[i][7:0];
      end
   end

   assign src_pixel  = '{alpha: alpha_ff, red: src_chan[2], green: src_chan[1],
                         blue: src_chan[0]};
   assign over_pixel = '{alpha: over_chan[3], red: over_chan[2], green: over_chan[1],
                         blue: over_chan[0]};
   assign alpha_zero = (alpha_ff == 8'd0);

endmodule

@@ rtl/core/alpha_mask_overlay_compositor_core.sv @@
// Premultiplied BGRA overlay canvas with source-over blending of coverage-mask pixels.
// A blend, read or convert request is taken when start is high and busy is low; its
// result appears on the rsp_ ports for one cycle with rsp_valid, after the request has
// passed S_ALPHA, S_SCALE, S_PREMUL and S_OVER, and busy stays high until then,
// so no new request is taken before the last one's result is shown. The sequence is set
// by the canvas memory's one read port (read issued, data registered) and the two
// registered multiply steps (alpha, then channel scaling). A clear request sweeps the
// canvas one word a cycle: busy stays high while all CANVAS_WIDTH*CANVAS_HEIGHT words
// (8192 at the defaults) are written, and the all-zero result follows the last write.
// After reset the same sweep runs, without a result, before the first request is taken.
// The receiver cannot stall: each result must be taken in the cycle it is shown.
module alpha_mask_overlay_compositor_core #(
   parameter int CANVAS_WIDTH  = amoc_pkg::CANVAS_WIDTH_DEFAULT,
   parameter int CANVAS_HEIGHT = amoc_pkg::CANVAS_HEIGHT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_pos_x,
   input  logic [6:0]  req_pos_y,
   input  logic [7:0]  req_mask,
   input  logic [31:0] req_color_word,
   output logic        rsp_valid,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_out_of_range
);

   localparam int DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALPHA,
      S_SCALE,
      S_PREMUL,
      S_OVER,
      S_CLEAR
   } state_type;

   state_type               state_ff, state_in;
   amoc_pkg::command_type   cmd_ff, cmd_in;
   logic                    oor_ff, oor_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [7:0]              mask_ff, mask_in;
   logic [7:0]              opacity_ff, opacity_in;
   logic [7:0]              blue_ff, blue_in;
   logic [7:0]              green_ff, green_in;
   logic [7:0]              red_ff, red_in;
   logic [ADDR_W-1:0]       clear_idx_ff, clear_idx_in;
   logic                    clear_rsp_ff, clear_rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   amoc_pkg::pixel_type     rsp_pixel_ff, rsp_pixel_in;
   logic                    rsp_oor_ff, rsp_oor_in;

   logic [15:0]             idx_full;
   logic                    req_oor;
   amoc_pkg::command_type   req_cmd;

   logic                    ram_en;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_addr;
   amoc_pkg::pixel_type     ram_wdata;
   amoc_pkg::pixel_type     ram_rdata;

   amoc_pkg::blend_ctrl_type blend_ctrl;
   amoc_pkg::pixel_type     src_pixel;
   amoc_pkg::pixel_type     over_pixel;
   logic                    alpha_zero;

   assign req_cmd  = amoc_pkg::command_type'(req_command);
   assign idx_full = 16'(req_pos_y) * 16'(CANVAS_WIDTH) + 16'(req_pos_x);
   assign req_oor  = ({1'b0, req_pos_x} >= 9'(CANVAS_WIDTH)) ||
                     ({1'b0, req_pos_y} >= 8'(CANVAS_HEIGHT));

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      oor_in       = oor_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      opacity_in   = opacity_ff;
      blue_in      = blue_ff;
      green_in     = green_ff;
      red_in       = red_ff;
      clear_idx_in = clear_idx_ff;
      clear_rsp_in = clear_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_oor_in   = rsp_oor_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in     = req_cmd;
               oor_in     = req_oor;
               addr_in    = idx_full[ADDR_W-1:0];
               mask_in    = req_mask;
               opacity_in = 8'hff - req_color_word[7:0];
               red_in     = req_color_word[31:24];
               green_in   = req_color_word[23:16];
               blue_in    = req_color_word[15:8];
               if (req_cmd == amoc_pkg::CMD_CLEAR) begin
                  state_in     = S_CLEAR;
                  clear_idx_in = '0;
                  clear_rsp_in = 1'b1;
               end else begin
                  state_in = S_ALPHA;
               end
            end
         end
         S_ALPHA:  state_in = S_SCALE;
         S_SCALE:  state_in = S_PREMUL;
         S_PREMUL: state_in = S_OVER;
         S_OVER: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_oor_in   = oor_ff;
            if (oor_ff) begin
               rsp_pixel_in = '0;
            end else begin
               case (cmd_ff)
                  amoc_pkg::CMD_READ:    rsp_pixel_in = ram_rdata;
                  amoc_pkg::CMD_CONVERT: rsp_pixel_in = src_pixel;
                  default:               rsp_pixel_in = alpha_zero ? ram_rdata : over_pixel;
               endcase
            end
         end
         S_CLEAR: begin
            if (clear_idx_ff == LAST_IDX) begin
               state_in     = S_IDLE;
               clear_rsp_in = 1'b0;
               if (clear_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_pixel_in = '0;
                  rsp_oor_in   = 1'b0;
               end
            end else begin
               clear_idx_in = clear_idx_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_idx_ff <= '0;
         clear_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         clear_rsp_ff <= clear_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_oor_ff   <= rsp_oor_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      oor_ff     <= oor_in;
      addr_ff    <= addr_in;
      mask_ff    <= mask_in;
      opacity_ff <= opacity_in;
      blue_ff    <= blue_in;
      green_ff   <= green_in;
      red_ff     <= red_in;
   end

   // one request in flight: write-back ends before the next read, no forwarding
   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = addr_ff;
      ram_wdata = over_pixel;
      if (state_ff == S_ALPHA) begin
         ram_en = 1'b1;
      end else if (state_ff == S_OVER) begin
         ram_we = (cmd_ff == amoc_pkg::CMD_BLEND) && !oor_ff && !alpha_zero;
         ram_en = ram_we;
      end else if (state_ff == S_CLEAR) begin
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = clear_idx_ff;
         ram_wdata = '0;
      end
   end

   assign blend_ctrl = '{alpha_mul: (state_ff == S_ALPHA),
                         alpha_div: (state_ff == S_SCALE),
                         chan_mul:  (state_ff == S_PREMUL)};

   amoc_canvas_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_canvas (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   amoc_blend u_blend (
      .clock      (clock),
      .ctrl       (blend_ctrl),
      .mask       (mask_ff),
      .opacity    (opacity_ff),
      .src_blue   (blue_ff),
      .src_green  (green_ff),
      .src_red    (red_ff),
      .dst        (ram_rdata),
      .src_pixel  (src_pixel),
      .over_pixel (over_pixel),
      .alpha_zero (alpha_zero)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blue         = rsp_pixel_ff.blue;
   assign rsp_green        = rsp_pixel_ff.green;
   assign rsp_red          = rsp_pixel_ff.red;
   assign rsp_alpha        = rsp_pixel_ff.alpha;
   assign rsp_out_of_range = rsp_oor_ff;

`ifndef SYNTHESIS
   a_pixel_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != amoc_pkg::CMD_CLEAR) |-> ##5 rsp_valid)
      else $error("pixel request result missing after five cycles");

   a_no_rsp_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid)
      else $error("result shown during canvas sweep");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_OVER || state_ff == S_CLEAR))
      else $error("canvas written outside write-back or sweep");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_blue == 8'd0 && rsp_green == 8'd0 && rsp_red == 8'd0 && rsp_alpha == 8'd0))
      else $error("out of range result carries a pixel");
`endif

endmodule
